/* design/att_pkg.sv */
package att_pkg;

   // field widths
   localparam int TIME_W        = 48;
   localparam int ID_W          = 16;
   localparam int INT_W         = 32;
   localparam int OP_W          = 3;
   localparam int KIND_W        = 3;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int RW            = $clog2(MAX_RESULTS);

   localparam logic [TIME_W-1:0] HALF_KEY = {1'b1, {(TIME_W-1){1'b0}}};

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_REG     = 3'd1;
   localparam logic [OP_W-1:0] OP_UNREG   = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FIRED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REG   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNREG = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RESET = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd4;

   // what a pass over the slot memory looks for
   typedef enum logic [1:0] {
      SK_DUE   = 2'd0,
      SK_ALLOC = 2'd1,
      SK_FIND  = 2'd2,
      SK_NEXT  = 2'd3
   } scan_kind_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [INT_W-1:0]  interval;
      logic              rep;
      logic [TIME_W-1:0] due;
   } entry_type;

   typedef struct packed {
      logic              clr;
      logic              vld;
      scan_kind_type     kind;
      logic [TIME_W-1:0] now;
      logic [ID_W-1:0]   aid;
      logic [ID_W-1:0]   id_base;
   } scan_ctl_type;

   typedef struct packed {
      logic              found;
      entry_type         ent;
      logic [TIME_W-1:0] key;
   } best_type;

endpackage

/* design/alarm_timer_table_top.sv */
// Alarm timer table: NUM_SLOTS alarm slots held in one synchronous memory, plus a 48-bit tick
// clock and an id counter. One item is taken at a time; req_tready is high only while idle.
// Every lookup is a pass over the slot memory through its single read port. Register,
// unregister and reset take two passes and one result beat, but a register with every slot
// full takes one pass; query and clear take one pass. A tick takes one pass per fired alarm
// plus one more that finds nothing due (left out once sixteen have fired), then a final pass
// for the earliest alarm, and gives one beat per fired alarm. A tick with nothing due gives
// no beat. Every beat carries the earliest pending alarm after the operation; rsp_tlast marks
// the final beat of an item. Opcodes six and seven are taken and dropped without a beat.
module alarm_timer_table_top import att_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // interval_ticks[31:0], repeat_req[32], alarm_id[48:33]
   input  logic [2:0]  req_tuser,  // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // result_id[15:0], status[16], next_id[32:17],
                                   // next_due[80:33]
   output logic [2:0]  rsp_tuser,  // kind[2:0]
   output logic        rsp_tlast
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int UW = NUM_SLOTS + 2;
   localparam int OW = $clog2(UW);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_APPLY = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [INT_W-1:0]  int_ff, int_in;
   logic              rep_ff, rep_in;
   logic [ID_W-1:0]   aid_ff, aid_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [ID_W-1:0]   idctr_ff, idctr_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   scan_kind_type     skind_ff, skind_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              proc_vld_ff, proc_vld_in;
   logic [IW-1:0]     proc_idx_ff;
   logic [RW:0]       fire_cnt_ff, fire_cnt_in;
   logic [RW-1:0]     emit_idx_ff, emit_idx_in;
   logic [ID_W-1:0]   fire_buf [MAX_RESULTS];
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic              res_st_ff, res_st_in;
   logic [KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [ID_W-1:0]   nid_ff, nid_in;
   logic [TIME_W-1:0] ndue_ff, ndue_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;

   // slot memory
   entry_type         mem [NUM_SLOTS];
   entry_type         rd_data_ff;
   logic [IW-1:0]     rd_addr;
   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   entry_type         mem_wdata;

   logic              buf_we;
   logic              start_scan;
   scan_kind_type     start_kind;
   scan_ctl_type      sctl;
   best_type          best;
   logic [IW-1:0]     best_idx;
   logic [UW-1:0]     used;
   logic [OW-1:0]     free_off;
   logic [IW-1:0]     free_slot;
   logic              all_full;
   logic              accept, rsp_fire, beat_last, scan_done;
   logic [ID_W-1:0]   rid;

   assign accept   = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign rd_addr  = rd_cnt_ff[IW-1:0];
   assign scan_done = proc_vld_ff && (proc_idx_ff == IW'(NUM_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) fire_buf[fire_cnt_ff[RW-1:0]] <= best.ent.id;
   end

   // lowest free slot and lowest unused id offset
   always_comb begin
      free_slot = '0;
      all_full  = 1'b1;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IW'(i);
            all_full  = 1'b0;
         end
      end
      free_off = '0;
      for (int k = UW - 1; k >= 0; k--) begin
         if (!used[k]) free_off = OW'(k);
      end
   end

   assign sctl.clr     = start_scan;
   assign sctl.vld     = proc_vld_ff;
   assign sctl.kind    = skind_ff;
   assign sctl.now     = time_ff;
   assign sctl.aid     = aid_ff;
   assign sctl.id_base = idctr_ff;

   att_scan #(.NUM_SLOTS(NUM_SLOTS)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sctl),
      .idx      (proc_idx_ff),
      .slot_vld (valid_ff[proc_idx_ff]),
      .entry    (rd_data_ff),
      .best     (best),
      .best_idx (best_idx),
      .used     (used)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      int_in      = int_ff;
      rep_in      = rep_ff;
      aid_in      = aid_ff;
      time_in     = time_ff;
      idctr_in    = idctr_ff;
      valid_in    = valid_ff;
      skind_in    = skind_ff;
      rd_cnt_in   = rd_cnt_ff;
      fire_cnt_in = fire_cnt_ff;
      emit_idx_in = emit_idx_ff;
      res_id_in   = res_id_ff;
      res_st_in   = res_st_ff;
      res_kind_in = res_kind_ff;
      nid_in      = nid_ff;
      ndue_in     = ndue_ff;
      free_idx_in = free_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = best_idx;
      mem_wdata   = best.ent;
      buf_we      = 1'b0;
      start_scan  = 1'b0;
      start_kind  = SK_NEXT;
      proc_vld_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_tuser;
               int_in      = (req_tdata[31:0] == '0) ? INT_W'(1) : req_tdata[31:0];
               rep_in      = req_tdata[32];
               aid_in      = req_tdata[48:33];
               res_st_in   = 1'b0;
               res_id_in   = req_tdata[48:33];
               fire_cnt_in = (RW+1)'(1);
               free_idx_in = free_slot;
               unique case (req_tuser)
                  OP_TICK: begin
                     time_in     = time_ff + TIME_W'(1);
                     fire_cnt_in = '0;
                     res_kind_in = KIND_FIRED;
                     start_scan  = 1'b1;
                     start_kind  = SK_DUE;
                  end
                  OP_REG: begin
                     res_kind_in = KIND_REG;
                     start_scan  = 1'b1;
                     if (all_full) begin
                        res_id_in  = '0;
                        res_st_in  = 1'b1;
                        start_kind = SK_NEXT;
                     end else begin
                        start_kind = SK_ALLOC;
                     end
                  end
                  OP_UNREG: begin
                     res_kind_in = KIND_UNREG;
                     start_scan  = 1'b1;
                     start_kind  = SK_FIND;
                  end
                  OP_RESET: begin
                     res_kind_in = KIND_RESET;
                     start_scan  = 1'b1;
                     start_kind  = SK_FIND;
                  end
                  OP_QUERY: begin
                     res_kind_in = KIND_NEXT;
                     start_scan  = 1'b1;
                     start_kind  = SK_NEXT;
                  end
                  OP_CLEAR: begin
                     res_kind_in = KIND_UNREG;
                     res_id_in   = '0;
                     valid_in    = '0;
                     start_scan  = 1'b1;
                     start_kind  = SK_NEXT;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_cnt_ff < CW'(NUM_SLOTS)) begin
               proc_vld_in = 1'b1;
               rd_cnt_in   = rd_cnt_ff + CW'(1);
            end
            if (scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            unique case (skind_ff)
               SK_DUE: begin
                  start_scan = 1'b1;
                  start_kind = SK_NEXT;
                  if (best.found) begin
                     buf_we      = 1'b1;
                     fire_cnt_in = fire_cnt_ff + (RW+1)'(1);
                     if (best.ent.rep) begin
                        mem_we        = 1'b1;
                        mem_wdata.due = time_ff + TIME_W'(best.ent.interval);
                     end else begin
                        valid_in[best_idx] = 1'b0;
                     end
                     if (fire_cnt_in < (RW+1)'(MAX_RESULTS)) start_kind = SK_DUE;
                  end
               end
               SK_ALLOC: begin
                  res_id_in          = idctr_ff + ID_W'(free_off);
                  idctr_in           = res_id_in + ID_W'(1);
                  mem_we             = 1'b1;
                  mem_waddr          = free_idx_ff;
                  mem_wdata.id       = res_id_in;
                  mem_wdata.interval = int_ff;
                  mem_wdata.rep      = rep_ff;
                  mem_wdata.due      = time_ff + TIME_W'(int_ff);
                  valid_in[free_idx_ff] = 1'b1;
                  start_scan         = 1'b1;
                  start_kind         = SK_NEXT;
               end
               SK_FIND: begin
                  res_st_in  = !best.found;
                  start_scan = 1'b1;
                  start_kind = SK_NEXT;
                  if (best.found) begin
                     if (op_ff == OP_UNREG) begin
                        valid_in[best_idx] = 1'b0;
                     end else begin
                        mem_we        = 1'b1;
                        mem_wdata.due = time_ff + TIME_W'(best.ent.interval);
                     end
                  end
               end
               SK_NEXT: begin
                  nid_in  = best.found ? best.ent.id : '0;
                  ndue_in = (best.found && best.key > HALF_KEY) ? best.ent.due : time_ff;
                  if (op_ff == OP_QUERY) res_id_in = nid_in;
                  emit_idx_in = '0;
                  state_in = (fire_cnt_ff == '0) ? S_IDLE : S_EMIT;
               end
               default: ;
            endcase
         end
         S_EMIT: begin
            if (rsp_fire) begin
               emit_idx_in = emit_idx_ff + RW'(1);
               if (beat_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (start_scan) begin
         state_in  = S_SCAN;
         skind_in  = start_kind;
         rd_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         time_ff     <= '0;
         idctr_ff    <= ID_W'(1);
         valid_ff    <= '0;
         proc_vld_ff <= 1'b0;
         fire_cnt_ff <= '0;
         emit_idx_ff <= '0;
         skind_ff    <= SK_NEXT;
         rd_cnt_ff   <= '0;
         op_ff       <= OP_QUERY;
      end else begin
         state_ff    <= state_in;
         time_ff     <= time_in;
         idctr_ff    <= idctr_in;
         valid_ff    <= valid_in;
         proc_vld_ff <= proc_vld_in;
         fire_cnt_ff <= fire_cnt_in;
         emit_idx_ff <= emit_idx_in;
         skind_ff    <= skind_in;
         rd_cnt_ff   <= rd_cnt_in;
         op_ff       <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= rd_addr;
      int_ff      <= int_in;
      rep_ff      <= rep_in;
      aid_ff      <= aid_in;
      res_id_ff   <= res_id_in;
      res_st_ff   <= res_st_in;
      res_kind_ff <= res_kind_in;
      nid_ff      <= nid_in;
      ndue_ff     <= ndue_in;
      free_idx_ff <= free_idx_in;
   end

   // result beats
   assign rid        = (op_ff == OP_TICK) ? fire_buf[emit_idx_ff] : res_id_ff;
   assign beat_last  = ({1'b0, emit_idx_ff} == fire_cnt_ff - (RW+1)'(1));
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tuser  = res_kind_ff;
   assign rsp_tlast  = beat_last;
   assign rsp_tdata  = {7'd0, ndue_ff, nid_ff, res_st_ff, rid};

   // checks
   a_fire_cnt: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= (RW+1)'(MAX_RESULTS))
      else $error("fire count beyond limit");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fire_cnt_ff != '0)
      else $error("beat with no pending result");

   // unused opcodes are dropped and leave the block idle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser <= OP_CLEAR)) |=> !req_tready)
      else $error("item taken while busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> req_tready)
      else $error("not idle after final beat");

endmodule

/* design/att_scan.sv */
module att_scan import att_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
   localparam int UW = NUM_SLOTS + 2,
   localparam int OW = $clog2(UW)
) (
   input  logic           clock,
   input  logic           reset,
   input  scan_ctl_type   ctl,
   input  logic [IW-1:0]  idx,
   input  logic           slot_vld,
   input  entry_type      entry,
   output best_type       best,
   output logic [IW-1:0]  best_idx,
   output logic [UW-1:0]  used
);

   logic              found_ff, found_in;
   entry_type         ent_ff;
   logic [TIME_W-1:0] key_ff;
   logic [IW-1:0]     idx_ff;
   logic [UW-1:0]     used_ff, used_in;
   logic [TIME_W-1:0] key;
   logic [ID_W-1:0]   d_off, z_off;
   logic              take;

   // order key: signed distance from now, offset by half range
   always_comb begin
      key   = (entry.due - ctl.now) ^ HALF_KEY;
      d_off = entry.id - ctl.id_base;
      z_off = ID_W'(0) - ctl.id_base;
      take  = 1'b0;
      unique case (ctl.kind)
         SK_DUE:   take = slot_vld && (key <= HALF_KEY) && (!found_ff || key < key_ff);
         SK_NEXT:  take = slot_vld && (!found_ff || key < key_ff);
         SK_FIND:  take = slot_vld && (entry.id == ctl.aid) && !found_ff;
         SK_ALLOC: take = 1'b0;
         default:  take = 1'b0;
      endcase
   end

   // id offsets already taken, zero counts as taken
   always_comb begin
      used_in  = used_ff;
      found_in = found_ff;
      if (ctl.clr) begin
         used_in  = '0;
         found_in = 1'b0;
         if (z_off < ID_W'(UW)) used_in[z_off[OW-1:0]] = 1'b1;
      end else if (ctl.vld) begin
         if (take) found_in = 1'b1;
         if (ctl.kind == SK_ALLOC && slot_vld && d_off < ID_W'(UW))
            used_in[d_off[OW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      used_ff <= used_in;
      if (!ctl.clr && ctl.vld && take) begin
         ent_ff <= entry;
         key_ff <= key;
         idx_ff <= idx;
      end
   end

   assign best.found = found_ff;
   assign best.ent   = ent_ff;
   assign best.key   = key_ff;
   assign best_idx   = idx_ff;
   assign used       = used_ff;

endmodule
